[hdl/admm_pkg.sv]
// ============================================================================
// admm_pkg - shared types and constants of the arcade drive mecanum mixer
// Field widths, register codes and reset values, divider sizing and the
// side-band record that rides along the divider pipeline.
// ============================================================================
`default_nettype none

package admm_pkg;

    // Field widths
    localparam int DMD_W = 17;              // demand fields, Q15 signed
    localparam int CMD_W = 16;              // command fields, Q15 signed
    localparam int RATIO_W = 16;            // wheel ratio, Q12 unsigned
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 2'd1;

    // Reset values
    localparam logic               SQUARE_RST = 1'b1;
    localparam logic [RATIO_W-1:0] RATIO_RST  = 16'd4602;  // 25.0 / 22.25 in Q12

    // Rear mix sizing: |rear| stays below 2^33 in Q27
    localparam int MAG_W = 34;
    localparam int Q_W   = 16;                // quotient holds up to 32768
    localparam int NUM_W = MAG_W + Q_W;       // dividend: mag << 15 plus half divisor
    localparam logic [MAG_W-1:0] ONE_Q27 = 34'd1 << 27;

    // Front commands travel beside the rear math
    typedef struct packed {
        logic [CMD_W-1:0] fl;
        logic [CMD_W-1:0] fr;
    } t_front;

    // Side-band record carried through the divider
    typedef struct packed {
        t_front      front;
        logic        neg_l;     // rear left is negative
        logic        neg_r;     // rear right is negative
        logic        norm;      // larger rear magnitude above one
        logic [14:0] nn_l;      // rounded and saturated rear left, no normalization
        logic [14:0] nn_r;
    } t_side;

endpackage

`default_nettype wire

[hdl/admm_dmd_if.sv]
// ============================================================================
// admm_dmd_if - demand channel
// Valid/ready channel carrying one move and rotate demand pair per item.
// ============================================================================
`default_nettype none

interface admm_dmd_if;
    import admm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [DMD_W-1:0] move_value;
    logic signed [DMD_W-1:0] rotate_value;

    modport source (output valid, move_value, rotate_value, input ready);
    modport sink   (input valid, move_value, rotate_value, output ready);
endinterface

`default_nettype wire

[hdl/admm_cmd_if.sv]
// ============================================================================
// admm_cmd_if - motor command channel
// Valid/ready channel carrying the four motor commands of one item.
// ============================================================================
`default_nettype none

interface admm_cmd_if;
    import admm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] front_left_command;
    logic signed [CMD_W-1:0] front_right_command;
    logic signed [CMD_W-1:0] rear_left_command;
    logic signed [CMD_W-1:0] rear_right_command;

    modport source (output valid, front_left_command, front_right_command,
                    rear_left_command, rear_right_command, input ready);
    modport sink   (input valid, front_left_command, front_right_command,
                    rear_left_command, rear_right_command, output ready);
endinterface

`default_nettype wire

[hdl/admm_div_pipe.sv]
// ============================================================================
// admm_div_pipe - pipelined restoring divider for rear normalization
// Two dividends share one divisor; each stage resolves one quotient bit,
// most significant first. Valid and side-band data move with the stages.
// ============================================================================
`default_nettype none

module admm_div_pipe (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_vld,
    input  wire admm_pkg::t_side             i_side,
    input  wire logic [admm_pkg::NUM_W-1:0]  i_num_l,
    input  wire logic [admm_pkg::NUM_W-1:0]  i_num_r,
    input  wire logic [admm_pkg::MAG_W-1:0]  i_den,
    output logic                             o_vld,
    output admm_pkg::t_side                  o_side,
    output logic [admm_pkg::Q_W-1:0]         o_q_l,
    output logic [admm_pkg::Q_W-1:0]         o_q_r
);
    import admm_pkg::*;

    logic             r_vld   [Q_W];
    t_side            r_side  [Q_W];
    logic [NUM_W-1:0] r_rem_l [Q_W];
    logic [NUM_W-1:0] r_rem_r [Q_W];
    logic [MAG_W-1:0] r_den   [Q_W];
    logic [Q_W-1:0]   r_q_l   [Q_W];
    logic [Q_W-1:0]   r_q_r   [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int BIT = Q_W - 1 - s;

        logic             v_in;
        t_side            side_in;
        logic [NUM_W-1:0] rem_l_in, rem_r_in, sub;
        logic [MAG_W-1:0] den_in;
        logic [Q_W-1:0]   q_l_in, q_r_in;
        logic [NUM_W:0]   dif_l, dif_r;
        logic [NUM_W-1:0] n_rem_l, n_rem_r;
        logic [Q_W-1:0]   n_q_l, n_q_r;

        // stage inputs
        if (s == 0) begin : g_first
            assign v_in     = i_vld;
            assign side_in  = i_side;
            assign rem_l_in = i_num_l;
            assign rem_r_in = i_num_r;
            assign den_in   = i_den;
            assign q_l_in   = '0;
            assign q_r_in   = '0;
        end else begin : g_next
            assign v_in     = r_vld[s-1];
            assign side_in  = r_side[s-1];
            assign rem_l_in = r_rem_l[s-1];
            assign rem_r_in = r_rem_r[s-1];
            assign den_in   = r_den[s-1];
            assign q_l_in   = r_q_l[s-1];
            assign q_r_in   = r_q_r[s-1];
        end

        // trial subtract of the shifted divisor
        assign sub   = NUM_W'(den_in) << BIT;
        assign dif_l = {1'b0, rem_l_in} - {1'b0, sub};
        assign dif_r = {1'b0, rem_r_in} - {1'b0, sub};

        always_comb begin
            n_rem_l = dif_l[NUM_W] ? rem_l_in : dif_l[NUM_W-1:0];
            n_rem_r = dif_r[NUM_W] ? rem_r_in : dif_r[NUM_W-1:0];
            n_q_l   = q_l_in | (dif_l[NUM_W] ? Q_W'(0) : Q_W'(1) << BIT);
            n_q_r   = q_r_in | (dif_r[NUM_W] ? Q_W'(0) : Q_W'(1) << BIT);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s]  <= side_in;
                r_rem_l[s] <= n_rem_l;
                r_rem_r[s] <= n_rem_r;
                r_den[s]   <= den_in;
                r_q_l[s]   <= n_q_l;
                r_q_r[s]   <= n_q_r;
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_side = r_side[Q_W-1];
    assign o_q_l  = r_q_l[Q_W-1];
    assign o_q_r  = r_q_r[Q_W-1];

endmodule

`default_nettype wire

[hdl/arcade_drive_mecanum_mixer_top.sv]
// ============================================================================
// arcade_drive_mecanum_mixer_top - arcade drive mixer with mecanum rear
// Clamps and optionally squares the demands, mixes left/right speeds, forms
// and normalizes the rear mecanum speeds and emits four motor commands.
// ============================================================================
// The block takes one demand item per clock and returns one command item via
// seven stages of clamp, square, mix, multiply, sum, magnitude and scale,
// sixteen stages of the rear normalization divider (one quotient bit per
// stage) and the output register. A single enable moves the whole pipeline;
// it is held only while a command waits at the output and the sink is not
// ready, so with a ready sink the rate is one item per cycle. The user writes
// square_inputs and wheel_ratio on the plain config port only while no item
// is in flight, unchecked by the block; writes to other indexes are dropped.
`default_nettype none

module arcade_drive_mecanum_mixer_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [admm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [admm_pkg::RATIO_W-1:0]    i_cfg_data,
    admm_dmd_if.sink                             i_dmd,
    admm_cmd_if.source                           o_cmd
);
    import admm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic               r_square;
    logic [RATIO_W-1:0] r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= SQUARE_RST;
            r_ratio  <= RATIO_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SQUARE) r_square <= i_cfg_data[0];
            if (i_cfg_idx == CFG_RATIO)  r_ratio  <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: one enable for every stage
    // ------------------------------------------------------------------
    logic en;
    logic r_o_vld;

    assign en          = !r_o_vld || o_cmd.ready;
    assign i_dmd.ready = en;

    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld;

    // ------------------------------------------------------------------
    // Stage A: clamp demands to +/-32767
    // ------------------------------------------------------------------
    function automatic logic signed [CMD_W-1:0] clamp_q15(input logic signed [DMD_W-1:0] v);
        logic signed [CMD_W-1:0] r;
        if (v > 17'sd32767)       r = 16'sd32767;
        else if (v < -17'sd32767) r = -16'sd32767;
        else                      r = v[CMD_W-1:0];
        return r;
    endfunction

    logic signed [CMD_W-1:0] r_a_mv, r_a_rv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mv <= clamp_q15(i_dmd.move_value);
            r_a_rv <= clamp_q15(i_dmd.rotate_value);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: optional sign-keeping square, Q30 rounded back to Q15
    // ------------------------------------------------------------------
    function automatic logic signed [CMD_W-1:0] signed_square(input logic signed [CMD_W-1:0] v);
        logic [CMD_W-1:0] neg;
        logic [14:0]      mag;
        logic [29:0]      prod;
        logic [CMD_W-1:0] sq;
        neg  = -v;
        mag  = v[CMD_W-1] ? neg[14:0] : v[14:0];
        prod = 30'(mag) * 30'(mag) + 30'd16384;
        sq   = {1'b0, prod[29:15]};
        return v[CMD_W-1] ? -sq : sq;
    endfunction

    logic signed [CMD_W-1:0] r_b_mv, r_b_rv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_mv <= r_square ? signed_square(r_a_mv) : r_a_mv;
            r_b_rv <= r_square ? signed_square(r_a_rv) : r_a_rv;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: arcade max rules into left and right speeds
    // ------------------------------------------------------------------
    logic signed [17:0] n_c_left, n_c_right;
    logic signed [17:0] r_c_left, r_c_right;

    always_comb begin
        logic signed [17:0] m, r, nm, nr;
        logic               r_pos;
        m     = {{2{r_b_mv[CMD_W-1]}}, r_b_mv};
        r     = {{2{r_b_rv[CMD_W-1]}}, r_b_rv};
        nm    = -m;
        nr    = -r;
        r_pos = !r[17] && (r != 18'sd0);
        if (!m[17]) begin
            if (r_pos) begin
                n_c_left  = m - r;
                n_c_right = (m > r) ? m : r;
            end else begin
                n_c_left  = (m > nr) ? m : nr;
                n_c_right = m + r;
            end
        end else begin
            if (r_pos) begin
                n_c_left  = (nm > r) ? m : nr;      // -max(-m, r)
                n_c_right = m + r;
            end else begin
                n_c_left  = m - r;
                n_c_right = (nm > nr) ? m : r;      // -max(-m, -r)
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_left  <= n_c_left;
            r_c_right <= n_c_right;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: rear gain products, front commands
    // ------------------------------------------------------------------
    logic signed [17:0] gp, gm, neg_left, neg_right;
    logic signed [35:0] r_d_lp, r_d_lm, r_d_rp, r_d_rm;
    t_front             r_d_front;

    assign gp        = $signed({2'b00, r_ratio}) + 18'sd2048;
    assign gm        = 18'sd2048 - $signed({2'b00, r_ratio});
    assign neg_left  = -r_c_left;
    assign neg_right = -r_c_right;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_lp         <= r_c_left * gp;
            r_d_lm         <= r_c_left * gm;
            r_d_rp         <= r_c_right * gp;
            r_d_rm         <= r_c_right * gm;
            r_d_front.fl   <= neg_right[CMD_W-1:0];
            r_d_front.fr   <= neg_left[CMD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage E: rear sums in Q27
    // ------------------------------------------------------------------
    logic signed [35:0] r_e_rl, r_e_rr;
    t_front             r_e_front;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_rl    <= r_d_lp + r_d_rm;
            r_e_rr    <= r_d_rp + r_d_lm;
            r_e_front <= r_d_front;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: magnitudes and signs
    // ------------------------------------------------------------------
    logic signed [35:0] neg_rl, neg_rr;
    logic [MAG_W-1:0]   r_f_ml, r_f_mr;
    logic               r_f_neg_l, r_f_neg_r;
    t_front             r_f_front;

    assign neg_rl = -r_e_rl;
    assign neg_rr = -r_e_rr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_ml    <= r_e_rl[35] ? neg_rl[MAG_W-1:0] : r_e_rl[MAG_W-1:0];
            r_f_mr    <= r_e_rr[35] ? neg_rr[MAG_W-1:0] : r_e_rr[MAG_W-1:0];
            r_f_neg_l <= r_e_rl[35];
            r_f_neg_r <= r_e_rr[35];
            r_f_front <= r_e_front;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: larger magnitude, plain rounding, divider operands
    // ------------------------------------------------------------------
    function automatic logic [14:0] round_q27(input logic [MAG_W-1:0] m);
        logic [MAG_W:0] s;
        logic [22:0]    q;
        s = {1'b0, m} + (MAG_W+1)'(2048);
        q = s[MAG_W:12];
        return (q > 23'd32767) ? 15'h7FFF : q[14:0];
    endfunction

    logic [MAG_W-1:0] mx;
    logic [NUM_W-1:0] half_mx;
    logic [MAG_W-1:0] r_g_den;
    logic [NUM_W-1:0] r_g_num_l, r_g_num_r;
    t_side            r_g_side;

    assign mx      = (r_f_ml > r_f_mr) ? r_f_ml : r_f_mr;
    assign half_mx = NUM_W'(mx >> 1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_den         <= mx;
            r_g_num_l       <= {1'b0, r_f_ml, 15'b0} + half_mx;
            r_g_num_r       <= {1'b0, r_f_mr, 15'b0} + half_mx;
            r_g_side.front  <= r_f_front;
            r_g_side.neg_l  <= r_f_neg_l;
            r_g_side.neg_r  <= r_f_neg_r;
            r_g_side.norm   <= mx > ONE_Q27;
            r_g_side.nn_l   <= round_q27(r_f_ml);
            r_g_side.nn_r   <= round_q27(r_f_mr);
        end
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_dmd.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
    end

    // ------------------------------------------------------------------
    // Normalization divider
    // ------------------------------------------------------------------
    logic             div_vld;
    t_side            div_side;
    logic [Q_W-1:0]   div_q_l, div_q_r;

    admm_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_g_vld),
        .i_side  (r_g_side),
        .i_num_l (r_g_num_l),
        .i_num_r (r_g_num_r),
        .i_den   (r_g_den),
        .o_vld   (div_vld),
        .o_side  (div_side),
        .o_q_l   (div_q_l),
        .o_q_r   (div_q_r)
    );

    // ------------------------------------------------------------------
    // Output stage: pick path, saturate, restore sign
    // ------------------------------------------------------------------
    function automatic logic [CMD_W-1:0] rear_cmd(input logic norm, input logic neg,
                                                  input logic [Q_W-1:0] q,
                                                  input logic [14:0] nn);
        logic [14:0]      mag;
        logic [CMD_W-1:0] m;
        if (norm) mag = (q > 16'd32767) ? 15'h7FFF : q[14:0];
        else      mag = nn;
        m = {1'b0, mag};
        return neg ? -m : m;
    endfunction

    logic [CMD_W-1:0] r_o_fl, r_o_fr, r_o_rl, r_o_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_fl <= div_side.front.fl;
            r_o_fr <= div_side.front.fr;
            r_o_rl <= rear_cmd(div_side.norm, div_side.neg_l, div_q_l, div_side.nn_l);
            r_o_rr <= rear_cmd(div_side.norm, div_side.neg_r, div_q_r, div_side.nn_r);
        end
    end

    assign o_cmd.valid               = r_o_vld;
    assign o_cmd.front_left_command  = r_o_fl;
    assign o_cmd.front_right_command = r_o_fr;
    assign o_cmd.rear_left_command   = r_o_rl;
    assign o_cmd.rear_right_command  = r_o_rr;

endmodule

`default_nettype wire

[hdl/admm_checker.sv]
// ============================================================================
// admm_checker - port-level checks of the mixer
// Watches the channels of the top level and is bound to it below.
// ============================================================================
`default_nettype none

module admm_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [admm_pkg::CMD_W-1:0]  i_fl,
    input wire logic [admm_pkg::CMD_W-1:0]  i_fr,
    input wire logic [admm_pkg::CMD_W-1:0]  i_rl,
    input wire logic [admm_pkg::CMD_W-1:0]  i_rr
);
    import admm_pkg::*;

    localparam logic [CMD_W-1:0] MOST_NEG = {1'b1, {(CMD_W-1){1'b0}}};

    // rear commands are saturated to +/-32767
    a_rear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_rl != MOST_NEG) && (i_rr != MOST_NEG))
        else $error("rear command outside +/-32767");

    // an empty output never blocks the input side
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while output is empty");

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fl) && $stable(i_fr)
                                        && $stable(i_rl) && $stable(i_rr))
        else $error("stalled command item changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind arcade_drive_mecanum_mixer_top admm_checker u_admm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_dmd.ready),
    .i_out_valid (o_cmd.valid),
    .i_out_ready (o_cmd.ready),
    .i_fl        (o_cmd.front_left_command),
    .i_fr        (o_cmd.front_right_command),
    .i_rl        (o_cmd.rear_left_command),
    .i_rr        (o_cmd.rear_right_command)
);

`default_nettype wire
